/* rtl/ccm_pkg.sv */
// ccm_pkg: shared types, codes and hash constants for the chunk coordinate hash map.
// Used by every module in rtl/; depends on nothing.
package ccm_pkg;

	localparam int SLOT_COUNT_DEF = 64;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [31:0] MIX_C1    = 32'h7feb352d;
	localparam logic [31:0] MIX_C2    = 32'h846ca68b;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_INSERTED  = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_REMOVED   = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] kx;
		logic [31:0] ky;
		logic [31:0] kz;
		logic [15:0] hd;
	} req_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] kx;
		logic [31:0] ky;
		logic [31:0] kz;
		logic [15:0] hd;
	} entry_t;

endpackage

/* rtl/chunk_coord_hash_map_unit.sv */
// chunk_coord_hash_map_unit: top level of the chunk coordinate hash map.
// Depends on ccm_pkg, ccm_front, ccm_queue, ccm_back.
//
// Open-addressing map from a signed (x, y, z) chunk coordinate to a 16-bit
// handle, with linear probing. A command beat is taken when start is high and
// busy is low. Each command yields exactly one result beat: done is high for
// one cycle with status and handle_out, and the receiver cannot hold it off.
// After reset the unit sweeps the slot memory once to clear the valid marks,
// with busy high. The front end hashes the key with five serial 32x32
// multiplies and queues the request; busy drops as soon as the request enters
// the two-beat queue, so the next key is hashed while the probe engine works.
// Busy stays high from each accepted beat through hashing and the push, so a
// new beat is taken only after the last one is pushed, and later while the
// queue is full. The probe engine reads each slot visited through a
// registered memory read (B_RD, then B_CHK) and registers the result. A remove
// also rehashes and reseats every entry of the cluster behind the freed slot.
// Inserts report full once three quarters of the slots are taken; the table
// never grows.
module chunk_coord_hash_map_unit import ccm_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] key_x,
	input  logic signed [31:0] key_y,
	input  logic signed [31:0] key_z,
	input  logic [15:0]        new_handle,
	output logic               done,
	output logic [2:0]         status,
	output logic [15:0]        handle_out
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int QW    = $bits(req_t) + IDX_W;

	req_t             req_in;
	req_t             f_req;
	logic [IDX_W-1:0] f_home;
	logic             push;
	logic             q_full;
	logic             q_empty;
	logic             pop;
	logic [QW-1:0]    q_dout;
	logic             clearing;

	// key words are hashed and compared as raw bits
	assign req_in = '{cmd: cmd, kx: key_x, ky: key_y, kz: key_z, hd: new_handle};

	ccm_front #(.IDX_W(IDX_W)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.clearing(clearing), .req_in(req_in), .push(push),
		.req_out(f_req), .home_out(f_home), .q_full(q_full)
	);

	ccm_queue #(.DW(QW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din({f_req, f_home}),
		.full(q_full), .pop(pop), .dout(q_dout), .empty(q_empty)
	);

	ccm_back #(.SLOT_COUNT(SLOT_COUNT), .IDX_W(IDX_W)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty),
		.q_req(q_dout[QW-1:IDX_W]), .q_home(q_dout[IDX_W-1:0]),
		.pop(pop), .clearing(clearing), .done(done),
		.status(status), .handle_out(handle_out)
	);

endmodule

/* rtl/ccm_hash.sv */
// ccm_hash: iterative FNV-1a plus xorshift-multiply finalizer, one 32x32 multiply per cycle.
// Depends on ccm_pkg.
module ccm_hash import ccm_pkg::*; #(
	parameter int IDX_W = $clog2(SLOT_COUNT_DEF)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [31:0]      kx,
	input  logic [31:0]      ky,
	input  logic [31:0]      kz,
	output logic             done,
	output logic [IDX_W-1:0] slot
);

	logic [31:0] h_q;
	logic [2:0]  step_q;
	logic        run_q;
	logic        done_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [31:0] prod;
	logic [31:0] fin;

	// keys are sampled in the run cycles, so the caller holds them stable
	always_comb begin
		case (step_q)
			3'd0: begin op_a = FNV_BASIS ^ kx; op_b = FNV_PRIME; end
			3'd1: begin op_a = h_q ^ ky; op_b = FNV_PRIME; end
			3'd2: begin op_a = h_q ^ kz; op_b = FNV_PRIME; end
			3'd3: begin op_a = h_q ^ (h_q >> 16); op_b = MIX_C1; end
			default: begin op_a = h_q ^ (h_q >> 15); op_b = MIX_C2; end
		endcase
		prod = op_a * op_b;
		fin  = h_q ^ (h_q >> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= 3'd0;
			end else if (run_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd4) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q && !start)
			h_q <= prod;
	end

	assign done = done_q;
	assign slot = fin[IDX_W-1:0];

endmodule

/* rtl/ccm_queue.sv */
// ccm_queue: two-entry FIFO between the front end and the table engine.
// Depends on ccm_pkg.
module ccm_queue import ccm_pkg::*; #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] din,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] dout,
	output logic          empty
);

	localparam int DEPTH = 2;

	logic [DW-1:0] mem_q [DEPTH];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	assign full  = (cnt_q == 2'(DEPTH));
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full)
				wp_q <= ~wp_q;
			if (pop && !empty)
				rp_q <= ~rp_q;
			if ((push && !full) && !(pop && !empty))
				cnt_q <= cnt_q + 2'd1;
			else if (!(push && !full) && (pop && !empty))
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wp_q] <= din;
	end

endmodule

/* rtl/ccm_front.sv */
// ccm_front: takes command beats, hashes the key to its home slot, queues the request.
// Depends on ccm_pkg and ccm_hash.
module ccm_front import ccm_pkg::*; #(
	parameter int IDX_W = $clog2(SLOT_COUNT_DEF)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             clearing,
	input  req_t             req_in,
	output logic             push,
	output req_t             req_out,
	output logic [IDX_W-1:0] home_out,
	input  logic             q_full
);

	typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_t;

	fstate_t          state_q;
	req_t             req_q;
	logic [IDX_W-1:0] home_q;
	logic             hstart;
	logic             hdone;
	logic [IDX_W-1:0] hslot;

	assign busy     = (state_q != F_IDLE) || clearing;
	assign hstart   = start && !busy;
	assign push     = (state_q == F_PUSH) && !q_full;
	assign req_out  = req_q;
	assign home_out = home_q;

	ccm_hash #(.IDX_W(IDX_W)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(hstart),
		.kx(req_q.kx), .ky(req_q.ky), .kz(req_q.kz),
		.done(hdone), .slot(hslot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (hstart) state_q <= F_HASH;
				F_HASH: if (hdone) state_q <= F_PUSH;
				F_PUSH: if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hstart)
			req_q <= req_in;
		if (hdone)
			home_q <= hslot;
	end

endmodule

/* rtl/ccm_back.sv */
// ccm_back: probe engine over the slot memory; lookup, insert, remove with cluster reinsert.
// Depends on ccm_pkg and ccm_hash.
module ccm_back import ccm_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  req_t             q_req,
	input  logic [IDX_W-1:0] q_home,
	output logic             pop,
	output logic             clearing,
	output logic             done,
	output logic [2:0]       status,
	output logic [15:0]      handle_out
);

	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int LIMIT = SLOT_COUNT - SLOT_COUNT / 4;

	typedef enum logic [3:0] {
		B_CLEAR, B_IDLE, B_RD, B_CHK, B_RM_RD, B_RM_CHK, B_RM_HASH, B_PL_RD, B_PL_CHK
	} bstate_t;

	entry_t mem [SLOT_COUNT];
	entry_t rdata_s1;

	bstate_t          state_q;
	req_t             req_q;
	entry_t           ent_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] nxt_q;
	logic [IDX_W:0]   n_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [2:0]       status_q;
	logic [15:0]      handle_q;

	logic [IDX_W-1:0] rd_addr;
	logic             we;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic             match;
	logic             last;
	logic             has_room;
	logic             hstart;
	logic             hdone;
	logic [IDX_W-1:0] hslot;

	assign rd_addr  = (state_q == B_RM_RD) ? nxt_q : idx_q;
	assign match    = rdata_s1.valid && (rdata_s1.kx == req_q.kx) &&
	                  (rdata_s1.ky == req_q.ky) && (rdata_s1.kz == req_q.kz);
	assign last     = (n_q == (IDX_W+1)'(SLOT_COUNT - 1));
	assign has_room = (cnt_q < CNT_W'(LIMIT));
	assign hstart   = (state_q == B_RM_CHK) && rdata_s1.valid;
	assign pop      = (state_q == B_IDLE) && !q_empty;
	assign clearing = (state_q == B_CLEAR);

	ccm_hash #(.IDX_W(IDX_W)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(hstart),
		.kx(ent_q.kx), .ky(ent_q.ky), .kz(ent_q.kz),
		.done(hdone), .slot(hslot)
	);

	always_comb begin
		we      = 1'b0;
		wr_addr = idx_q;
		wr_data = '0;
		case (state_q)
			B_CLEAR: we = 1'b1;
			B_CHK: begin
				if (req_q.cmd == CMD_INSERT && !rdata_s1.valid && has_room) begin
					we      = 1'b1;
					wr_data = '{valid: 1'b1, kx: req_q.kx, ky: req_q.ky,
					            kz: req_q.kz, hd: req_q.hd};
				end else if (req_q.cmd == CMD_REMOVE && match) begin
					we = 1'b1;
				end
			end
			B_RM_CHK: begin
				we      = rdata_s1.valid;
				wr_addr = nxt_q;
			end
			B_PL_CHK: begin
				we      = !rdata_s1.valid;
				wr_data = ent_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_CLEAR;
			idx_q    <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			status_q <= ST_NOT_FOUND;
			handle_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				B_CLEAR: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == IDX_W'(SLOT_COUNT - 1))
						state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (!q_empty) begin
						req_q <= q_req;
						idx_q <= q_home;
						n_q   <= '0;
						if (q_req.cmd == CMD_UNUSED) begin
							done_q   <= 1'b1;
							status_q <= ST_NOT_FOUND;
							handle_q <= '0;
						end else begin
							state_q <= B_RD;
						end
					end
				end
				B_RD: state_q <= B_CHK;
				B_CHK: begin
					if (match) begin
						if (req_q.cmd == CMD_REMOVE) begin
							cnt_q   <= cnt_q - CNT_W'(1);
							nxt_q   <= idx_q + IDX_W'(1);
							n_q     <= '0;
							state_q <= B_RM_RD;
						end else begin
							done_q   <= 1'b1;
							status_q <= ST_FOUND;
							handle_q <= rdata_s1.hd;
							state_q  <= B_IDLE;
						end
					end else if (!rdata_s1.valid || last) begin
						// key absent: end of walk
						done_q   <= 1'b1;
						handle_q <= '0;
						state_q  <= B_IDLE;
						if (req_q.cmd == CMD_INSERT) begin
							if (!rdata_s1.valid && has_room) begin
								status_q <= ST_INSERTED;
								handle_q <= req_q.hd;
								cnt_q    <= cnt_q + CNT_W'(1);
							end else begin
								status_q <= ST_FULL;
							end
						end else begin
							status_q <= ST_NOT_FOUND;
						end
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						n_q     <= n_q + (IDX_W+1)'(1);
						state_q <= B_RD;
					end
				end
				B_RM_RD: begin
					if (n_q == (IDX_W+1)'(SLOT_COUNT)) begin
						done_q   <= 1'b1;
						status_q <= ST_REMOVED;
						handle_q <= '0;
						state_q  <= B_IDLE;
					end else begin
						state_q <= B_RM_CHK;
					end
				end
				B_RM_CHK: begin
					if (!rdata_s1.valid) begin
						done_q   <= 1'b1;
						status_q <= ST_REMOVED;
						handle_q <= '0;
						state_q  <= B_IDLE;
					end else begin
						ent_q   <= rdata_s1;
						state_q <= B_RM_HASH;
					end
				end
				B_RM_HASH: begin
					if (hdone) begin
						idx_q   <= hslot;
						state_q <= B_PL_RD;
					end
				end
				B_PL_RD: state_q <= B_PL_CHK;
				B_PL_CHK: begin
					// the vacated slot is always on the walk, so this ends
					if (!rdata_s1.valid) begin
						nxt_q   <= nxt_q + IDX_W'(1);
						n_q     <= n_q + (IDX_W+1)'(1);
						state_q <= B_RM_RD;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= B_PL_RD;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign handle_out = handle_q;

endmodule

/* verif/chunk_coord_hash_map_unit_tb.sv */
// chunk_coord_hash_map_unit_tb: self-checking bench for the chunk coordinate hash map.
// Depends on ccm_pkg and chunk_coord_hash_map_unit; a local map model predicts each result.
module chunk_coord_hash_map_unit_tb;
	import ccm_pkg::*;

	localparam int SLOTS = SLOT_COUNT_DEF;
	localparam int LOAD_LIMIT = SLOTS - SLOTS / 4;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic signed [31:0] key_x;
	logic signed [31:0] key_y;
	logic signed [31:0] key_z;
	logic [15:0]        new_handle;
	logic               done;
	logic [2:0]         status;
	logic [15:0]        handle_out;

	chunk_coord_hash_map_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .key_x(key_x), .key_y(key_y), .key_z(key_z),
		.new_handle(new_handle), .done(done), .status(status),
		.handle_out(handle_out)
	);

	typedef struct packed {
		logic [2:0]  st;
		logic [15:0] hd;
	} answer_t;

	// model copy of the slot memory
	entry_t  map_slot [SLOTS];
	int      map_fill;
	answer_t answers_due [$];
	int      mismatches;
	int      answers_seen;
	int      cmd_sent [4];
	int      full_seen;
	int      gap_pct;

	// pool of coordinates so inserts, hits and removes land on the same keys
	logic [31:0] pool_x [128];
	logic [31:0] pool_y [128];
	logic [31:0] pool_z [128];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("timeout with %0d results outstanding", answers_due.size());
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic [31:0] slot_home(logic [31:0] kx, logic [31:0] ky,
			logic [31:0] kz);
		logic [31:0] h;
		h = 32'd2166136261;
		h = (h ^ kx) * 32'd16777619;
		h = (h ^ ky) * 32'd16777619;
		h = (h ^ kz) * 32'd16777619;
		h = h ^ (h >> 16);
		h = h * 32'h7feb352d;
		h = h ^ (h >> 15);
		h = h * 32'h846ca68b;
		h = h ^ (h >> 16);
		return h & (SLOTS - 1);
	endfunction

	function automatic int slot_find(logic [31:0] kx, logic [31:0] ky, logic [31:0] kz);
		int i;
		i = slot_home(kx, ky, kz);
		for (int n = 0; n < SLOTS; n++) begin
			if (!map_slot[i].valid)
				return -1;
			if (map_slot[i].kx == kx && map_slot[i].ky == ky && map_slot[i].kz == kz)
				return i;
			i = (i + 1) & (SLOTS - 1);
		end
		return -1;
	endfunction

	function automatic bit slot_seat(logic [31:0] kx, logic [31:0] ky, logic [31:0] kz,
			logic [15:0] hd);
		int i;
		i = slot_home(kx, ky, kz);
		for (int n = 0; n < SLOTS; n++) begin
			if (!map_slot[i].valid) begin
				map_slot[i] = '{1'b1, kx, ky, kz, hd};
				map_fill++;
				return 1'b1;
			end
			i = (i + 1) & (SLOTS - 1);
		end
		return 1'b0;
	endfunction

	// clear the slot, then reseat the cluster that follows it
	function automatic void slot_vacate(int at);
		int nx;
		nx = (at + 1) & (SLOTS - 1);
		map_slot[at].valid = 1'b0;
		map_fill--;
		for (int n = 0; n < SLOTS && map_slot[nx].valid; n++) begin
			map_slot[nx].valid = 1'b0;
			map_fill--;
			if (!slot_seat(map_slot[nx].kx, map_slot[nx].ky, map_slot[nx].kz,
					map_slot[nx].hd)) begin
				map_slot[nx].valid = 1'b1;
				map_fill++;
			end
			nx = (nx + 1) & (SLOTS - 1);
		end
	endfunction

	function automatic answer_t map_apply(logic [1:0] c, logic [31:0] kx, logic [31:0] ky,
			logic [31:0] kz, logic [15:0] hd);
		answer_t a;
		int at;
		a = '{ST_NOT_FOUND, 16'd0};
		if (c == CMD_UNUSED)
			return a;
		at = slot_find(kx, ky, kz);
		case (c)
			CMD_LOOKUP: begin
				if (at >= 0)
					a = '{ST_FOUND, map_slot[at].hd};
			end
			CMD_INSERT: begin
				if (at >= 0)
					a = '{ST_FOUND, map_slot[at].hd};
				else if (map_fill >= LOAD_LIMIT)
					a = '{ST_FULL, 16'd0};
				else if (slot_seat(kx, ky, kz, hd))
					a = '{ST_INSERTED, hd};
				else
					a = '{ST_FULL, 16'd0};
			end
			default: begin
				if (at >= 0) begin
					slot_vacate(at);
					a = '{ST_REMOVED, 16'd0};
				end
			end
		endcase
		return a;
	endfunction

	// one command beat; the prediction is queued when the beat is taken.
	// start stays high into the next call, which drops it only when it idles.
	task automatic send_cmd(logic [1:0] c, logic [31:0] kx, logic [31:0] ky,
			logic [31:0] kz, logic [15:0] hd);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		key_x <= kx;
		key_y <= ky;
		key_z <= kz;
		new_handle <= hd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		answers_due.push_back(map_apply(c, kx, ky, kz, hd));
		cmd_sent[c]++;
	endtask

	task automatic send_pool(logic [1:0] c, int k);
		send_cmd(c, pool_x[k], pool_y[k], pool_z[k], 16'($urandom));
	endtask

	// result checker
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			answers_seen++;
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result status %0d handle %h", status, handle_out);
			end else begin
				want = answers_due.pop_front();
				if (status == ST_FULL)
					full_seen++;
				if (status !== want.st || handle_out !== want.hd) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected status %0d handle %h, got %0d %h",
							answers_seen, want.st, want.hd, status, handle_out);
				end
			end
		end
	end

	task automatic drain;
		int guard;
		guard = 0;
		start <= 1'b0;
		while (answers_due.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
	endtask

	// extremes of the key fields, unused command, misses on an empty table, repeat inserts, hits, removes
	task automatic test_directed;
		send_cmd(CMD_LOOKUP, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'h0);
		send_cmd(CMD_REMOVE, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'h0);
		send_cmd(CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'hffff);
		send_cmd(CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'h1234);
		send_cmd(CMD_LOOKUP, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'h0);
		send_cmd(CMD_INSERT, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'h0);
		send_cmd(CMD_INSERT, 32'h0, 32'h0, 32'h0, 16'haaaa);
		send_cmd(CMD_INSERT, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 16'h5555);
		send_cmd(CMD_UNUSED, 32'h0, 32'h0, 32'h0, 16'hffff);
		send_cmd(CMD_UNUSED, 32'hffff_ffff, 32'h1, 32'h2, 16'h1);
		send_cmd(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 16'h0);
		send_cmd(CMD_REMOVE, 32'h0, 32'h0, 32'h0, 16'h0);
		send_cmd(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 16'h0);
		send_cmd(CMD_REMOVE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'h0);
		send_cmd(CMD_REMOVE, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'h0);
		send_cmd(CMD_REMOVE, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 16'h0);
	endtask

	// fill past three-quarter load so inserts report full, then look up and remove the lot
	task automatic test_fill_to_full;
		for (int k = 0; k < 60; k++)
			send_cmd(CMD_INSERT, k, -k, k * 7, 16'($urandom));
		for (int k = 0; k < 60; k++)
			send_cmd(CMD_LOOKUP, k, -k, k * 7, 16'h0);
		for (int k = 0; k < 60; k++)
			send_cmd(CMD_REMOVE, k, -k, k * 7, 16'h0);
	endtask

	// random mix over a small key pool, with a share of fully random keys
	task automatic test_random_mix(int count);
		int r;
		for (int n = 0; n < count; n++) begin
			gap_pct = (n % 600 < 150) ? 0 : 31;
			r = $urandom_range(99);
			if (r < 5)
				send_cmd(2'($urandom), $urandom, $urandom, $urandom, 16'($urandom));
			else if (r < 45)
				send_pool(CMD_INSERT, $urandom_range(127));
			else if (r < 72)
				send_pool(CMD_LOOKUP, $urandom_range(127));
			else if (r < 98)
				send_pool(CMD_REMOVE, $urandom_range(127));
			else
				send_pool(CMD_UNUSED, $urandom_range(127));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_LOOKUP;
		key_x = '0;
		key_y = '0;
		key_z = '0;
		new_handle = '0;
		mismatches = 0;
		answers_seen = 0;
		full_seen = 0;
		map_fill = 0;
		gap_pct = 31;
		foreach (map_slot[i])
			map_slot[i] = '0;
		foreach (cmd_sent[i])
			cmd_sent[i] = 0;
		// nearby coordinates collide in clusters, random ones spread out
		for (int k = 0; k < 128; k++) begin
			pool_x[k] = (k < 64) ? 32'(k % 4 - 2) : $urandom;
			pool_y[k] = (k < 64) ? 32'(k / 4 % 4 - 2) : $urandom;
			pool_z[k] = (k < 64) ? 32'(k / 16 - 2) : $urandom;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_fill_to_full();
		test_random_mix(1600);
		drain();

		$display("covered %0d lookups, %0d inserts, %0d removes, %0d unused commands",
			cmd_sent[CMD_LOOKUP], cmd_sent[CMD_INSERT], cmd_sent[CMD_REMOVE],
			cmd_sent[CMD_UNUSED]);
		$display("%0d results checked, %0d table-full answers", answers_seen, full_seen);
		if (mismatches == 0 && answers_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
